/* rtl/core/rbpyz_pkg.sv */
// rbpyz_pkg: shared types, constants and fixed-point helpers for the
// relativistic boris pusher core. Depends on nothing; used by every rtl/core file.
`default_nettype none

package rbpyz_pkg;

  // depth of the pipelined square root and divider units
  localparam int unsigned STAGES = 32;

  // Q16.16 one and the 2^32 offset of the gamma radicand
  localparam logic signed [63:0] FIX_ONE = 64'sd65536;
  localparam logic [63:0]        GAMMA_BASE = 64'h0000_0001_0000_0000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TIME_STEP   = 1'b0,
    CFG_HALF_CHARGE = 1'b1
  } cfg_idx_e;

  localparam int unsigned CFG_W = 31;

  // one particle in
  typedef struct packed {
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [31:0] charge_over_mass;
    logic signed [31:0] field_ex;
    logic signed [31:0] field_ey;
    logic signed [31:0] field_ez;
    logic signed [31:0] field_bx;
    logic signed [31:0] field_by;
    logic signed [31:0] field_bz;
  } item_t;

  // one particle out
  typedef struct packed {
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_mom_x;
    logic signed [31:0] new_mom_y;
    logic signed [31:0] new_mom_z;
    logic               saturated;
  } result_t;

  // per-particle context carried down the pipeline
  typedef struct packed {
    logic [31:0]       pos_y;
    logic [31:0]       pos_z;
    logic [2:0][31:0]  mom;
    logic [31:0]       qm;
    logic [2:0][31:0]  fe;
    logic [2:0][31:0]  fb;
    logic [31:0]       dq;
    logic [2:0][47:0]  ek;
    logic [2:0][31:0]  pm;
    logic [8:0][31:0]  mtx;
    logic              sat;
  } ctx_t;

  function automatic logic signed [63:0] sx32(input logic [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic signed [63:0] sx48(input logic [47:0] a);
    return {{16{a[47]}}, a};
  endfunction

  // magnitude of a signed 32-bit value as unsigned
  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (32'd0 - a) : a;
  endfunction

  // round to nearest (ties up) after a Q16.16 product
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // clip to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > 64'sd2147483647) || (x < -64'sd2147483648);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rbpyz_isqrt.sv */
// rbpyz_isqrt: pipelined integer square root of a 64-bit radicand, one
// result bit per stage, carrying the particle context. Depends on rbpyz_pkg.
`default_nettype none

module rbpyz_isqrt import rbpyz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] rad_i,
  input  ctx_t        ctx_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output ctx_t        ctx_o
);

  logic [STAGES-1:0] val_q;
  logic [63:0] rem_q [STAGES];
  logic [63:0] rt_q  [STAGES];
  ctx_t        ctx_q [STAGES];

  logic [63:0] rem_s [STAGES];
  logic [63:0] rt_s  [STAGES];
  logic [63:0] trial [STAGES];
  logic [63:0] rem_d [STAGES];
  logic [63:0] rt_d  [STAGES];

  function automatic logic [63:0] sq_bit(input int unsigned i);
    return 64'd1 << (2 * (STAGES - 1 - i));
  endfunction

  // stage inputs
  always_comb begin
    rem_s[0] = rad_i;
    rt_s[0]  = '0;
    for (int i = 1; i < STAGES; i++) begin
      rem_s[i] = rem_q[i-1];
      rt_s[i]  = rt_q[i-1];
    end
  end

  // one digit step per stage
  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      trial[i] = rt_s[i] + sq_bit(i);
      if (rem_s[i] >= trial[i]) begin
        rem_d[i] = rem_s[i] - trial[i];
        rt_d[i]  = (rt_s[i] >> 1) + sq_bit(i);
      end else begin
        rem_d[i] = rem_s[i];
        rt_d[i]  = rt_s[i] >> 1;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= {val_q[STAGES-2:0], valid_i};
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_i;
    for (int i = 1; i < STAGES; i++) begin
      ctx_q[i] <= ctx_q[i-1];
    end
    for (int i = 0; i < STAGES; i++) begin
      rem_q[i] <= rem_d[i];
      rt_q[i]  <= rt_d[i];
    end
  end

  assign valid_o = val_q[STAGES-1];
  assign root_o  = rt_q[STAGES-1][31:0];
  assign ctx_o   = ctx_q[STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/rbpyz_div.sv */
// rbpyz_div: pipelined restoring divider, 48-bit magnitude over 50-bit
// divisor, 32-bit truncated signed quotient, context carried. Depends on rbpyz_pkg.
`default_nettype none

module rbpyz_div import rbpyz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        neg_i,
  input  logic [47:0] num_i,
  input  logic [49:0] den_i,
  input  ctx_t        ctx_i,
  output logic        valid_o,
  output logic [31:0] quo_o,
  output ctx_t        ctx_o
);

  localparam int unsigned TW = 50 + STAGES;

  logic [STAGES-1:0] val_q;
  logic [STAGES-1:0] neg_q;
  logic [47:0] rem_q [STAGES];
  logic [49:0] den_q [STAGES];
  logic [31:0] quo_q [STAGES];
  ctx_t        ctx_q [STAGES];

  logic [47:0] rem_s [STAGES];
  logic [49:0] den_s [STAGES];
  logic [31:0] quo_s [STAGES];
  logic [TW-1:0] trial [STAGES];
  logic [47:0] rem_d [STAGES];
  logic [31:0] quo_d [STAGES];

  // stage inputs
  always_comb begin
    rem_s[0] = num_i;
    den_s[0] = den_i;
    quo_s[0] = '0;
    for (int i = 1; i < STAGES; i++) begin
      rem_s[i] = rem_q[i-1];
      den_s[i] = den_q[i-1];
      quo_s[i] = quo_q[i-1];
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      trial[i] = TW'(den_s[i]) << (STAGES - 1 - i);
      if (TW'(rem_s[i]) >= trial[i]) begin
        rem_d[i] = rem_s[i] - trial[i][47:0];
        quo_d[i] = {quo_s[i][30:0], 1'b1};
      end else begin
        rem_d[i] = rem_s[i];
        quo_d[i] = {quo_s[i][30:0], 1'b0};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= {val_q[STAGES-2:0], valid_i};
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    ctx_q[0] <= ctx_i;
    neg_q[0] <= neg_i;
    for (int i = 1; i < STAGES; i++) begin
      ctx_q[i] <= ctx_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
    for (int i = 0; i < STAGES; i++) begin
      rem_q[i] <= rem_d[i];
      den_q[i] <= den_s[i];
      quo_q[i] <= quo_d[i];
    end
  end

  // sign applied after the magnitude division: truncation toward zero
  assign valid_o = val_q[STAGES-1];
  assign quo_o   = neg_q[STAGES-1] ? (32'd0 - quo_q[STAGES-1]) : quo_q[STAGES-1];
  assign ctx_o   = ctx_q[STAGES-1];

endmodule

`default_nettype wire

/* rtl/core/relativistic_boris_push_yz_core.sv */
// relativistic_boris_push_yz_core: top level of the y-z relativistic boris
// pusher. Depends on rbpyz_pkg, rbpyz_isqrt and rbpyz_div.
//
//   channel   ports                                   transfer when
//   -------   -------------------------------------   ---------------------
//   particle  start, busy, item_i (item_t)            start high, busy low
//   result    strobe, result_o (result_t)             strobe high
//   config    cfg_we_i, cfg_idx_i, cfg_data_i         cfg_we_i high
//
// One particle is taken every clock cycle; busy is always low. Each particle
// passes through the chain of three gamma square roots (32 stages each),
// six dividers in four rounds (32 stages each) and the multiply, round and
// clip stages between them to become its result.
// Reset clears the configuration registers and all valid bits; in-flight
// particles are dropped. The receiver takes every result as it comes.
`default_nettype none

module relativistic_boris_push_yz_core import rbpyz_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  output logic             strobe,
  output result_t          result_o,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // configuration registers
  logic [CFG_W-1:0] dt_q, hcf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q  <= '0;
      hcf_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP:   dt_q  <= cfg_data_i;
        CFG_HALF_CHARGE: hcf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // stage signals
  logic a1_v_q, a2_v_q, d1_v_q, d2_v_q, k1_v_q, k2_v_q, k3_v_q, k4_v_q;
  logic k5_v_q, k6_v_q, t1_v_q, t2_v_q, t3_v_q, t4_v_q, r1_v_q, r2_v_q;
  logic r3_v_q, r4_v_q, a7_v_q, a8_v_q, e1_v_q, strobe_q;

  ctx_t a1_c_q, a2_c_q, d1_c_q, d2_c_q, k1_c_q, k2_c_q, k3_c_q, k4_c_q;
  ctx_t k5_c_q, k6_c_q, t1_c_q, t2_c_q, t3_c_q, t4_c_q, r1_c_q, r2_c_q;
  ctx_t r3_c_q, r4_c_q, a7_c_q, a8_c_q, e1_c_q;
  ctx_t a1_c_d, d2_c_d, k2_c_d, k4_c_d, t2_c_d, t4_c_d, r2_c_d, r4_c_d;

  logic [63:0] a1_sq_q [3];
  logic [63:0] a2_g_q;
  logic signed [63:0] d1_py_q, d1_pz_q;
  logic signed [63:0] k1_prod_q;
  logic signed [63:0] k3_prod_q [3];
  logic [63:0] k5_sq_q [3];
  logic [63:0] k6_g_q;
  logic signed [63:0] t1_prod_q [3];
  logic [2:0][31:0] t2_t_q, t3_t_q;
  logic signed [63:0] t3_sq_q [3];
  logic signed [63:0] t3_cr_q [3];
  logic [49:0] t4_den_q, t4_den_d;
  logic signed [63:0] r1_prod_q [9];
  logic [16:0] r1_f_q, r2_f_q;
  logic [2:0][31:0] r2_acc_q, r2_acc_d;
  logic r2_sat_d;
  logic signed [63:0] r3_prod_q [3];
  logic [63:0] a7_sq_q [3];
  logic [63:0] a8_g_q;
  logic signed [63:0] e1_py_q, e1_pz_q;
  result_t res_q, res_d;

  // unit outputs
  logic s1_v, s2_v, s3_v, dv1_v, dr_v, df_v, dv2_v;
  logic [31:0] s1_gam, s2_gam, s3_gam;
  logic [31:0] dv1_vy, dv1_vz, dr_root, df_f, dv2_vy, dv2_vz;
  ctx_t s1_c, s2_c, s3_c, dv1_c, dr_c, df_c, dv2_c;

  // ---------------------------------------------------------------------
  // particle into context
  always_comb begin
    a1_c_d        = '0;
    a1_c_d.pos_y  = item_i.pos_y;
    a1_c_d.pos_z  = item_i.pos_z;
    a1_c_d.mom[0] = item_i.mom_x;
    a1_c_d.mom[1] = item_i.mom_y;
    a1_c_d.mom[2] = item_i.mom_z;
    a1_c_d.qm     = item_i.charge_over_mass;
    a1_c_d.fe[0]  = item_i.field_ex;
    a1_c_d.fe[1]  = item_i.field_ey;
    a1_c_d.fe[2]  = item_i.field_ez;
    a1_c_d.fb[0]  = item_i.field_bx;
    a1_c_d.fb[1]  = item_i.field_by;
    a1_c_d.fb[2]  = item_i.field_bz;
  end

  // end of first drift
  always_comb begin
    d2_c_d       = d1_c_q;
    d2_c_d.pos_y = sat32(sx32(d1_c_q.pos_y) + ((d1_py_q + 64'sd65536) >>> 17));
    d2_c_d.pos_z = sat32(sx32(d1_c_q.pos_z) + ((d1_pz_q + 64'sd65536) >>> 17));
    d2_c_d.sat   = d1_c_q.sat
                 | ovf32(sx32(d1_c_q.pos_y) + ((d1_py_q + 64'sd65536) >>> 17))
                 | ovf32(sx32(d1_c_q.pos_z) + ((d1_pz_q + 64'sd65536) >>> 17));
  end

  // charge scale dq
  always_comb begin
    k2_c_d     = k1_c_q;
    k2_c_d.dq  = sat32(rnd16(k1_prod_q));
    k2_c_d.sat = k1_c_q.sat | ovf32(rnd16(k1_prod_q));
  end

  // half electric kick
  always_comb begin
    k4_c_d = k3_c_q;
    for (int k = 0; k < 3; k++) begin
      k4_c_d.ek[k] = 48'(rnd16(k3_prod_q[k]));
      k4_c_d.pm[k] = sat32(sx32(k3_c_q.mom[k]) + rnd16(k3_prod_q[k]));
      k4_c_d.sat   = k4_c_d.sat | ovf32(sx32(k3_c_q.mom[k]) + rnd16(k3_prod_q[k]));
    end
  end

  // clip flag of the rotation vector
  always_comb begin
    t2_c_d     = t1_c_q;
    t2_c_d.sat = t1_c_q.sat | ovf32(rnd16(t1_prod_q[0]))
               | ovf32(rnd16(t1_prod_q[1])) | ovf32(rnd16(t1_prod_q[2]));
  end

  // rotation matrix and its denominator
  logic signed [63:0] s0, s1, s2, cxy, cxz, cyz, tx2, ty2, tz2;
  logic signed [63:0] m_w [9];

  always_comb begin
    s0  = rnd16(t3_sq_q[0]);
    s1  = rnd16(t3_sq_q[1]);
    s2  = rnd16(t3_sq_q[2]);
    cxy = rnd16(t3_cr_q[0]) <<< 1;
    cxz = rnd16(t3_cr_q[1]) <<< 1;
    cyz = rnd16(t3_cr_q[2]) <<< 1;
    tx2 = sx32(t3_t_q[0]) <<< 1;
    ty2 = sx32(t3_t_q[1]) <<< 1;
    tz2 = sx32(t3_t_q[2]) <<< 1;
    m_w[0] = FIX_ONE + s0 - s1 - s2;
    m_w[1] = cxy + tz2;
    m_w[2] = cxz - ty2;
    m_w[3] = cxy - tz2;
    m_w[4] = FIX_ONE - s0 + s1 - s2;
    m_w[5] = cyz + tx2;
    m_w[6] = cxz + ty2;
    m_w[7] = cyz - tx2;
    m_w[8] = FIX_ONE - s0 - s1 + s2;
    t4_c_d = t3_c_q;
    for (int i = 0; i < 9; i++) begin
      t4_c_d.mtx[i] = sat32(m_w[i]);
      t4_c_d.sat    = t4_c_d.sat | ovf32(m_w[i]);
    end
    t4_den_d = 50'(FIX_ONE + s0 + s1 + s2);
  end

  // row sums
  logic signed [63:0] row_w [3];

  always_comb begin
    r2_sat_d = r1_c_q.sat;
    for (int i = 0; i < 3; i++) begin
      row_w[i] = rnd16(r1_prod_q[3*i]) + rnd16(r1_prod_q[3*i+1])
               + rnd16(r1_prod_q[3*i+2]);
      r2_acc_d[i] = sat32(row_w[i]);
      r2_sat_d    = r2_sat_d | ovf32(row_w[i]);
    end
    r2_c_d     = r1_c_q;
    r2_c_d.sat = r2_sat_d;
  end

  // scale by f and second half kick
  logic signed [63:0] sc_w [3];

  always_comb begin
    r4_c_d = r3_c_q;
    for (int i = 0; i < 3; i++) begin
      sc_w[i]       = sx32(sat32(rnd16(r3_prod_q[i]))) + sx48(r3_c_q.ek[i]);
      r4_c_d.mom[i] = sat32(sc_w[i]);
      r4_c_d.sat    = r4_c_d.sat | ovf32(rnd16(r3_prod_q[i])) | ovf32(sc_w[i]);
    end
  end

  // end of second drift
  always_comb begin
    res_d.new_pos_y = sat32(sx32(e1_c_q.pos_y) + ((e1_py_q + 64'sd65536) >>> 17));
    res_d.new_pos_z = sat32(sx32(e1_c_q.pos_z) + ((e1_pz_q + 64'sd65536) >>> 17));
    res_d.new_mom_x = e1_c_q.mom[0];
    res_d.new_mom_y = e1_c_q.mom[1];
    res_d.new_mom_z = e1_c_q.mom[2];
    res_d.saturated = e1_c_q.sat
                    | ovf32(sx32(e1_c_q.pos_y) + ((e1_py_q + 64'sd65536) >>> 17))
                    | ovf32(sx32(e1_c_q.pos_z) + ((e1_pz_q + 64'sd65536) >>> 17));
  end

  // ---------------------------------------------------------------------
  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q <= 1'b0; a2_v_q <= 1'b0; d1_v_q <= 1'b0; d2_v_q <= 1'b0;
      k1_v_q <= 1'b0; k2_v_q <= 1'b0; k3_v_q <= 1'b0; k4_v_q <= 1'b0;
      k5_v_q <= 1'b0; k6_v_q <= 1'b0; t1_v_q <= 1'b0; t2_v_q <= 1'b0;
      t3_v_q <= 1'b0; t4_v_q <= 1'b0; r1_v_q <= 1'b0; r2_v_q <= 1'b0;
      r3_v_q <= 1'b0; r4_v_q <= 1'b0; a7_v_q <= 1'b0; a8_v_q <= 1'b0;
      e1_v_q <= 1'b0; strobe_q <= 1'b0;
    end else begin
      a1_v_q <= start & ~busy;
      a2_v_q <= a1_v_q;
      d1_v_q <= dv1_v;
      d2_v_q <= d1_v_q;
      k1_v_q <= d2_v_q;
      k2_v_q <= k1_v_q;
      k3_v_q <= k2_v_q;
      k4_v_q <= k3_v_q;
      k5_v_q <= k4_v_q;
      k6_v_q <= k5_v_q;
      t1_v_q <= dr_v;
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= t3_v_q;
      r1_v_q <= df_v;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
      a7_v_q <= r4_v_q;
      a8_v_q <= a7_v_q;
      e1_v_q <= dv2_v;
      strobe_q <= e1_v_q;
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    // gamma of the input momentum
    a1_c_q <= a1_c_d;
    for (int k = 0; k < 3; k++) begin
      a1_sq_q[k] <= 64'(mag32(a1_c_d.mom[k])) * 64'(mag32(a1_c_d.mom[k]));
    end
    a2_c_q <= a1_c_q;
    a2_g_q <= GAMMA_BASE + a1_sq_q[0] + a1_sq_q[1] + a1_sq_q[2];

    // first drift
    d1_c_q  <= dv1_c;
    d1_py_q <= $signed({1'b0, dt_q}) * $signed(dv1_vy);
    d1_pz_q <= $signed({1'b0, dt_q}) * $signed(dv1_vz);
    d2_c_q  <= d2_c_d;

    // kick
    k1_c_q    <= d2_c_q;
    k1_prod_q <= $signed(d2_c_q.qm) * $signed({1'b0, hcf_q});
    k2_c_q    <= k2_c_d;
    k3_c_q    <= k2_c_q;
    for (int k = 0; k < 3; k++) begin
      k3_prod_q[k] <= $signed(k2_c_q.dq) * $signed(k2_c_q.fe[k]);
    end
    k4_c_q <= k4_c_d;
    k5_c_q <= k4_c_q;
    for (int k = 0; k < 3; k++) begin
      k5_sq_q[k] <= 64'(mag32(k4_c_q.pm[k])) * 64'(mag32(k4_c_q.pm[k]));
    end
    k6_c_q <= k5_c_q;
    k6_g_q <= GAMMA_BASE + k5_sq_q[0] + k5_sq_q[1] + k5_sq_q[2];

    // rotation vector
    t1_c_q <= dr_c;
    for (int k = 0; k < 3; k++) begin
      t1_prod_q[k] <= $signed(dr_c.fb[k]) * $signed(dr_root);
    end
    t2_c_q <= t2_c_d;
    for (int k = 0; k < 3; k++) begin
      t2_t_q[k] <= sat32(rnd16(t1_prod_q[k]));
    end
    t3_c_q <= t2_c_q;
    t3_t_q <= t2_t_q;
    for (int k = 0; k < 3; k++) begin
      t3_sq_q[k] <= $signed(t2_t_q[k]) * $signed(t2_t_q[k]);
    end
    t3_cr_q[0] <= $signed(t2_t_q[0]) * $signed(t2_t_q[1]);
    t3_cr_q[1] <= $signed(t2_t_q[0]) * $signed(t2_t_q[2]);
    t3_cr_q[2] <= $signed(t2_t_q[1]) * $signed(t2_t_q[2]);
    t4_c_q   <= t4_c_d;
    t4_den_q <= t4_den_d;

    // rotation and rescale
    r1_c_q <= df_c;
    r1_f_q <= df_f[16:0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1_prod_q[3*i+j] <= $signed(df_c.mtx[3*i+j]) * $signed(df_c.pm[j]);
      end
    end
    r2_c_q     <= r2_c_d;
    r2_acc_q   <= r2_acc_d;
    r2_f_q     <= r1_f_q;
    r3_c_q     <= r2_c_q;
    for (int i = 0; i < 3; i++) begin
      r3_prod_q[i] <= $signed(r2_acc_q[i]) * $signed({1'b0, r2_f_q});
    end
    r4_c_q <= r4_c_d;

    // gamma of the new momentum
    a7_c_q <= r4_c_q;
    for (int k = 0; k < 3; k++) begin
      a7_sq_q[k] <= 64'(mag32(r4_c_q.mom[k])) * 64'(mag32(r4_c_q.mom[k]));
    end
    a8_c_q <= a7_c_q;
    a8_g_q <= GAMMA_BASE + a7_sq_q[0] + a7_sq_q[1] + a7_sq_q[2];

    // second drift
    e1_c_q  <= dv2_c;
    e1_py_q <= $signed({1'b0, dt_q}) * $signed(dv2_vy);
    e1_pz_q <= $signed({1'b0, dt_q}) * $signed(dv2_vz);
    res_q   <= res_d;
  end

  // ---------------------------------------------------------------------
  // first drift: gamma and velocity
  rbpyz_isqrt u_sqrt_g1 (
    .clk_i, .rst_ni,
    .valid_i (a2_v_q), .rad_i (a2_g_q), .ctx_i (a2_c_q),
    .valid_o (s1_v), .root_o (s1_gam), .ctx_o (s1_c)
  );

  rbpyz_div u_div_vy1 (
    .clk_i, .rst_ni,
    .valid_i (s1_v), .neg_i (s1_c.mom[1][31]),
    .num_i ({mag32(s1_c.mom[1]), 16'h0}), .den_i (50'(s1_gam)), .ctx_i (s1_c),
    .valid_o (dv1_v), .quo_o (dv1_vy), .ctx_o (dv1_c)
  );

  rbpyz_div u_div_vz1 (
    .clk_i, .rst_ni,
    .valid_i (s1_v), .neg_i (s1_c.mom[2][31]),
    .num_i ({mag32(s1_c.mom[2]), 16'h0}), .den_i (50'(s1_gam)), .ctx_i (s1_c),
    .valid_o (), .quo_o (dv1_vz), .ctx_o ()
  );

  // kick: gamma of the kicked momentum and the rotation root
  rbpyz_isqrt u_sqrt_g2 (
    .clk_i, .rst_ni,
    .valid_i (k6_v_q), .rad_i (k6_g_q), .ctx_i (k6_c_q),
    .valid_o (s2_v), .root_o (s2_gam), .ctx_o (s2_c)
  );

  rbpyz_div u_div_root (
    .clk_i, .rst_ni,
    .valid_i (s2_v), .neg_i (s2_c.dq[31]),
    .num_i ({mag32(s2_c.dq), 16'h0}), .den_i (50'(s2_gam)), .ctx_i (s2_c),
    .valid_o (dr_v), .quo_o (dr_root), .ctx_o (dr_c)
  );

  // rescale factor 2^32 / denominator
  rbpyz_div u_div_f (
    .clk_i, .rst_ni,
    .valid_i (t4_v_q), .neg_i (1'b0),
    .num_i (48'h0001_0000_0000), .den_i (t4_den_q), .ctx_i (t4_c_q),
    .valid_o (df_v), .quo_o (df_f), .ctx_o (df_c)
  );

  // second drift: gamma and velocity
  rbpyz_isqrt u_sqrt_g3 (
    .clk_i, .rst_ni,
    .valid_i (a8_v_q), .rad_i (a8_g_q), .ctx_i (a8_c_q),
    .valid_o (s3_v), .root_o (s3_gam), .ctx_o (s3_c)
  );

  rbpyz_div u_div_vy2 (
    .clk_i, .rst_ni,
    .valid_i (s3_v), .neg_i (s3_c.mom[1][31]),
    .num_i ({mag32(s3_c.mom[1]), 16'h0}), .den_i (50'(s3_gam)), .ctx_i (s3_c),
    .valid_o (dv2_v), .quo_o (dv2_vy), .ctx_o (dv2_c)
  );

  rbpyz_div u_div_vz2 (
    .clk_i, .rst_ni,
    .valid_i (s3_v), .neg_i (s3_c.mom[2][31]),
    .num_i ({mag32(s3_c.mom[2]), 16'h0}), .den_i (50'(s3_gam)), .ctx_i (s3_c),
    .valid_o (), .quo_o (dv2_vz), .ctx_o ()
  );

  // result register
  assign strobe   = strobe_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

/* tb/tb.sv */
// tb: self-checking regression for relativistic_boris_push_yz_core.
// Uses rbpyz_pkg types and a local fixed-point model of the y-z boris push.
`timescale 1ns / 1ps

module tb;
  import rbpyz_pkg::*;

  localparam int  LATENCY    = 246;
  localparam int  CYCLE_CAP  = 200000;
  localparam int  PHASE_ITEMS = 320;
  localparam int  ROWS       = 8;
  localparam logic [30:0] REG_MAX = 31'h7fff_ffff;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  item_t            item_i = '0;
  logic             strobe;
  result_t          result_o;
  logic             cfg_we_i = 1'b0;
  cfg_idx_e         cfg_idx_i = CFG_TIME_STEP;
  logic [CFG_W-1:0] cfg_data_i = '0;

  relativistic_boris_push_yz_core dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .strobe, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // mirrored configuration and model flags
  longint  dt_mirror;
  longint  hcf_mirror;
  bit      clipped;
  int      errors;
  int      cycles;
  result_t pending_particles[$];

  item_t   row_item[ROWS];
  result_t row_exp[ROWS];

  // ---------------- fixed-point particle model ----------------

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // q16.16 product, round to nearest with ties up
  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint lorentz(longint a, longint b, longint c);
    longint unsigned g;
    longint unsigned ma, mb, mc;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mc = (c < 0) ? -c : c;
    g = (64'd1 << 32) + ma * ma + mb * mb + mc * mc;
    return longint'(root64(g));
  endfunction

  // drift y and z by half a step at velocity p/gamma
  function automatic void drift_half(inout longint y, inout longint z, input longint p[3]);
    longint gam, vy, vz;
    gam = lorentz(p[0], p[1], p[2]);
    vy = (p[1] * 64'sd65536) / gam;
    vz = (p[2] * 64'sd65536) / gam;
    y = clip32(y + ((dt_mirror * vy + 64'sd65536) >>> 17));
    z = clip32(z + ((dt_mirror * vz + 64'sd65536) >>> 17));
  endfunction

  function automatic result_t push_particle(item_t it);
    longint y, z, qm, dq, rt, two_xy, two_xz, two_yz, den, f, acc;
    longint p[3], e[3], b[3], ek[3], pm[3], t[3], s[3];
    longint m[3][3];
    result_t r;
    clipped = 1'b0;
    y = it.pos_y;
    z = it.pos_z;
    p[0] = it.mom_x; p[1] = it.mom_y; p[2] = it.mom_z;
    qm = it.charge_over_mass;
    e[0] = it.field_ex; e[1] = it.field_ey; e[2] = it.field_ez;
    b[0] = it.field_bx; b[1] = it.field_by; b[2] = it.field_bz;

    drift_half(y, z, p);

    // half electric kick, then magnetic rotation
    dq = clip32(qmul(qm, hcf_mirror));
    for (int i = 0; i < 3; i++) begin
      ek[i] = qmul(dq, e[i]);
      pm[i] = clip32(p[i] + ek[i]);
    end
    rt = (dq * 64'sd65536) / lorentz(pm[0], pm[1], pm[2]);
    for (int i = 0; i < 3; i++) begin
      t[i] = clip32(qmul(b[i], rt));
      s[i] = qmul(t[i], t[i]);
    end
    two_xy = 2 * qmul(t[0], t[1]);
    two_xz = 2 * qmul(t[0], t[2]);
    two_yz = 2 * qmul(t[1], t[2]);
    m[0][0] = clip32(64'sd65536 + s[0] - s[1] - s[2]);
    m[0][1] = clip32(two_xy + 2 * t[2]);
    m[0][2] = clip32(two_xz - 2 * t[1]);
    m[1][0] = clip32(two_xy - 2 * t[2]);
    m[1][1] = clip32(64'sd65536 - s[0] + s[1] - s[2]);
    m[1][2] = clip32(two_yz + 2 * t[0]);
    m[2][0] = clip32(two_xz + 2 * t[1]);
    m[2][1] = clip32(two_yz - 2 * t[0]);
    m[2][2] = clip32(64'sd65536 - s[0] - s[1] + s[2]);
    den = 64'sd65536 + s[0] + s[1] + s[2];
    f = (64'sd1 << 32) / den;

    // second half kick folded into each row
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc = acc + qmul(m[i][j], pm[j]);
      acc = clip32(acc);
      p[i] = clip32(clip32(qmul(acc, f)) + ek[i]);
    end

    drift_half(y, z, p);

    r.new_pos_y = y[31:0];
    r.new_pos_z = z[31:0];
    r.new_mom_x = p[0][31:0];
    r.new_mom_y = p[1][31:0];
    r.new_mom_z = p[2][31:0];
    r.saturated = clipped;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [31:0] pick_word();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      case ($urandom_range(0, 5))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        4: return 32'h0001_0000;
        default: return 32'hffff_0000;
      endcase
    end
    if (k < 70) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    return $urandom();
  endfunction

  function automatic item_t random_particle();
    item_t it;
    it.pos_y = pick_word();
    it.pos_z = pick_word();
    it.mom_x = pick_word();
    it.mom_y = pick_word();
    it.mom_z = pick_word();
    it.charge_over_mass = pick_word();
    it.field_ex = pick_word();
    it.field_ey = pick_word();
    it.field_ez = pick_word();
    it.field_bx = pick_word();
    it.field_by = pick_word();
    it.field_bz = pick_word();
    return it;
  endfunction

  function automatic item_t uniform_particle(logic [31:0] v);
    return {12{v}};
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_particle(item_t it, bit typed, result_t typed_exp);
    start  <= 1'b1;
    item_i <= it;
    while (busy) @(negedge clk_i);
    pending_particles.push_back(typed ? typed_exp : push_particle(it));
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_TIME_STEP) dt_mirror = longint'(val);
    else hcf_mirror = longint'(val);
    @(negedge clk_i);
  endtask

  // only touch the registers with the pipe drained
  task automatic set_step(logic [CFG_W-1:0] dt, logic [CFG_W-1:0] hcf);
    start <= 1'b0;
    while (pending_particles.size() != 0) @(negedge clk_i);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_HALF_CHARGE, hcf);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic stream(int n, int gap_pct);
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < gap_pct) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
      send_particle(random_particle(), 1'b0, '0);
    end
  endtask

  // ---------------- result checking ----------------

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && strobe) begin
      if (pending_particles.size() == 0) begin
        $error("result with no particle outstanding");
        errors++;
      end else begin
        want = pending_particles.pop_front();
        if (result_o.new_pos_y !== want.new_pos_y) begin
          $error("new_pos_y exp %h got %h", want.new_pos_y, result_o.new_pos_y);
          errors++;
        end
        if (result_o.new_pos_z !== want.new_pos_z) begin
          $error("new_pos_z exp %h got %h", want.new_pos_z, result_o.new_pos_z);
          errors++;
        end
        if (result_o.new_mom_x !== want.new_mom_x) begin
          $error("new_mom_x exp %h got %h", want.new_mom_x, result_o.new_mom_x);
          errors++;
        end
        if (result_o.new_mom_y !== want.new_mom_y) begin
          $error("new_mom_y exp %h got %h", want.new_mom_y, result_o.new_mom_y);
          errors++;
        end
        if (result_o.new_mom_z !== want.new_mom_z) begin
          $error("new_mom_z exp %h got %h", want.new_mom_z, result_o.new_mom_z);
          errors++;
        end
        if (result_o.saturated !== want.saturated) begin
          $error("saturated exp %b got %b", want.saturated, result_o.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("relativistic_boris_push_yz_core regression: fail");
      $finish;
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    errors = 0;
    cycles = 0;
    dt_mirror = 0;
    hcf_mirror = 0;

    // with both registers at reset the push is an exact pass-through
    row_item[0] = uniform_particle(32'h0000_0000);
    row_item[1] = uniform_particle(32'h7fff_ffff);
    row_item[2] = uniform_particle(32'h8000_0000);
    row_item[3] = uniform_particle(32'hffff_ffff);
    row_item[4] = uniform_particle(32'h0000_0001);
    row_item[5] = uniform_particle(32'h0001_0000);
    row_item[6] = {6{32'h7fff_ffff, 32'h8000_0000}};
    row_item[7] = {6{32'h5555_5555, 32'haaaa_aaaa}};
    row_exp[0] = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000, 1'b0};
    row_exp[1] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 1'b0};
    row_exp[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 1'b0};
    row_exp[3] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_ffff, 1'b0};
    row_exp[4] = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                   32'h0000_0001, 1'b0};
    row_exp[5] = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                   32'h0001_0000, 1'b0};
    row_exp[6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 1'b0};
    row_exp[7] = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                   32'h5555_5555, 1'b0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows at reset settings, then again at the largest settings and at dt 1.0, hcf 0.5
    for (int r = 0; r < ROWS; r++) send_particle(row_item[r], 1'b1, row_exp[r]);
    set_step(REG_MAX, REG_MAX);
    for (int r = 0; r < ROWS; r++) send_particle(row_item[r], 1'b0, '0);
    set_step(31'h0001_0000, 31'h0000_8000);
    for (int r = 0; r < ROWS; r++) send_particle(row_item[r], 1'b0, '0);

    // random particles across several step settings
    set_step(31'h0000_4000, 31'h0000_2000);
    stream(PHASE_ITEMS, 15);
    set_step(REG_MAX, REG_MAX);
    stream(PHASE_ITEMS, 15);
    set_step(31'($urandom()), 31'($urandom_range(0, 32'h0004_0000)));
    stream(PHASE_ITEMS, 64);
    set_step(31'h0000_0000, 31'($urandom()));
    stream(PHASE_ITEMS, 64);
    set_step(31'($urandom()), 31'h0000_0000);
    stream(PHASE_ITEMS, 0);
    set_step(31'h0001_0000, 31'h0000_0100);
    stream(PHASE_ITEMS, 0);

    // drain
    start <= 1'b0;
    while (pending_particles.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);

    if (errors == 0) begin
      $display("relativistic_boris_push_yz_core regression: pass");
    end else begin
      $display("relativistic_boris_push_yz_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rbpyz_pkg.sv
rtl/core/rbpyz_isqrt.sv
rtl/core/rbpyz_div.sv
rtl/core/relativistic_boris_push_yz_core.sv
tb/tb.sv
